/* hw/rtl/arc4_pkg.sv */
`timescale 1ns / 1ps

package arc4_pkg;

    // Permutation box geometry.
    localparam int BOX_SIZE = 256;
    localparam int BOX_AW   = 8;
    localparam int BYTE_W   = 8;

    // Key length register.
    localparam int             CFG_W         = 9;
    localparam logic [CFG_W-1:0] KEY_LEN_RESET = 9'd16;

    // Depth of the result buffer, and the width of a count up to it.
    localparam int OUT_DEPTH = 2;
    localparam int OUT_CW    = 2;

    // Item function codes.
    localparam logic [1:0] FN_LOAD_KEY = 2'd0;
    localparam logic [1:0] FN_SCHEDULE = 2'd1;
    localparam logic [1:0] FN_CRYPT    = 2'd2;

    // One access to the permutation memory, with its write and its read.
    typedef struct packed {
        logic              we;
        logic [BOX_AW-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [BOX_AW-1:0] raddr;
    } perm_req_t;

    // A finished result on its way into the output buffer.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } out_push_t;

endpackage

/* hw/rtl/arc4_stream_cipher.sv */
`timescale 1ns / 1ps

// RC4 stream cipher around a 256-byte permutation memory with one write port
// and one registered read port, plus a separate key memory. A key load item
// (func 0) is written at the accepting edge and the next item can follow in
// the next cycle unless every output buffer entry is promised. A crypt item
// (func 2) steps through ST_CR_RD_I, ST_CR_RD_J and ST_CR_RD_T for the three
// reads of the permutation memory (S[i], S[j], S[S[i]+S[j]]) that depend on
// one another; the next item can be taken in ST_CR_RD_T, and the result
// leaves through a two-entry output buffer. A key schedule item (func 1) with
// a nonzero key length holds off the next item through a start state, a sweep
// of all 256 entries writing the identity permutation, and 256 swap steps that
// read S[n] and S[acc] and write them back swapped. Crypting before any key
// schedule, or scheduling with unloaded key bytes, returns unspecified bytes.
module arc4_stream_cipher #(
    parameter int KEY_MAX = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  func,
    input  logic [7:0]                  key_index,
    input  logic [arc4_pkg::BYTE_W-1:0] in_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [arc4_pkg::BYTE_W-1:0] out_byte,
    input  logic                        key_length_we,
    input  logic [arc4_pkg::CFG_W-1:0]  key_length
);
    import arc4_pkg::*;

    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    logic [CFG_W-1:0]  key_length_reg;
    perm_req_t         perm_req;
    logic [BYTE_W-1:0] perm_rdata;
    logic              key_we;
    logic [KW-1:0]     key_waddr;
    logic [BYTE_W-1:0] key_wdata;
    logic [KW-1:0]     key_raddr;
    logic [BYTE_W-1:0] key_rdata;
    out_push_t         out_push;
    logic              out_pop;

    assign out_pop = out_valid && !out_stall;

    // Key length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= KEY_LEN_RESET;
        end
        else if (key_length_we)
        begin
            key_length_reg <= key_length;
        end
    end

    arc4_ctrl #(
        .KEY_MAX (KEY_MAX),
        .KW      (KW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .key_index  (key_index),
        .in_byte    (in_byte),
        .key_length (key_length_reg),
        .perm_req   (perm_req),
        .perm_rdata (perm_rdata),
        .key_we     (key_we),
        .key_waddr  (key_waddr),
        .key_wdata  (key_wdata),
        .key_raddr  (key_raddr),
        .key_rdata  (key_rdata),
        .out_push   (out_push),
        .out_pop    (out_pop)
    );

    arc4_perm_ram u_perm_ram (
        .clk   (clk),
        .req   (perm_req),
        .rdata (perm_rdata)
    );

    arc4_key_ram #(
        .DEPTH (KEY_MAX),
        .AW    (KW)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    arc4_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte)
    );

endmodule

/* hw/rtl/arc4_perm_ram.sv */
`timescale 1ns / 1ps

module arc4_perm_ram (
    input  logic                                clk,
    input  arc4_pkg::perm_req_t                 req,
    output logic [arc4_pkg::BYTE_W-1:0]         rdata
);
    import arc4_pkg::*;

    logic [BYTE_W-1:0] mem [BOX_SIZE];
    logic [BYTE_W-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/arc4_key_ram.sv */
`timescale 1ns / 1ps

module arc4_key_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [arc4_pkg::BYTE_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [arc4_pkg::BYTE_W-1:0] rdata
);
    import arc4_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Key bytes are written by load items and read by the key schedule.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/arc4_out_buf.sv */
`timescale 1ns / 1ps

module arc4_out_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  arc4_pkg::out_push_t         push,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [arc4_pkg::BYTE_W-1:0] out_byte
);
    import arc4_pkg::*;

    logic [BYTE_W-1:0] ent0_reg;
    logic [BYTE_W-1:0] ent1_reg;
    logic [BYTE_W-1:0] ent0_next;
    logic [BYTE_W-1:0] ent1_next;
    logic [OUT_CW-1:0] count_reg;
    logic [OUT_CW-1:0] count_next;
    logic [OUT_CW-1:0] left;
    logic              pop;

    assign out_valid = (count_reg != '0);
    assign out_byte  = ent0_reg;
    assign pop       = out_valid && !out_stall;

    // Shift on a pop, then place a new item behind what is left.
    always_comb
    begin
        left      = count_reg - OUT_CW'(pop);
        ent0_next = pop ? ent1_reg : ent0_reg;
        ent1_next = ent1_reg;
        if (push.valid)
        begin
            if (left == '0)
            begin
                ent0_next = push.data;
            end
            else
            begin
                ent1_next = push.data;
            end
        end
        count_next = left + OUT_CW'(push.valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

/* hw/rtl/arc4_ctrl.sv */
`timescale 1ns / 1ps

module arc4_ctrl #(
    parameter int KEY_MAX = 256,
    parameter int KW      = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  func,
    input  logic [7:0]                  key_index,
    input  logic [arc4_pkg::BYTE_W-1:0] in_byte,
    input  logic [arc4_pkg::CFG_W-1:0]  key_length,
    output arc4_pkg::perm_req_t         perm_req,
    input  logic [arc4_pkg::BYTE_W-1:0] perm_rdata,
    output logic                        key_we,
    output logic [KW-1:0]               key_waddr,
    output logic [arc4_pkg::BYTE_W-1:0] key_wdata,
    output logic [KW-1:0]               key_raddr,
    input  logic [arc4_pkg::BYTE_W-1:0] key_rdata,
    output arc4_pkg::out_push_t         out_push,
    input  logic                        out_pop
);
    import arc4_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_CR_RD_I = 10'b00_0000_0010,
        ST_CR_RD_J = 10'b00_0000_0100,
        ST_CR_RD_T = 10'b00_0000_1000,
        ST_KS_START = 10'b00_0001_0000,
        ST_KS_INIT = 10'b00_0010_0000,
        ST_KS_RD_N = 10'b00_0100_0000,
        ST_KS_RD_ACC = 10'b00_1000_0000,
        ST_KS_WR_N = 10'b01_0000_0000,
        ST_KS_WR_ACC = 10'b10_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        FWD_RAM,
        FWD_A,
        FWD_B
    } fwd_t;

    localparam logic [BOX_AW-1:0] LAST_N = BOX_AW'(BOX_SIZE - 1);

    state_t            state_reg;
    state_t            state_next;
    state_t            dispatch;

    logic [BOX_AW-1:0] i_reg;
    logic [BOX_AW-1:0] j_reg;
    logic [BYTE_W-1:0] a_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] cap_data_reg;
    logic              post_reg;
    logic [BOX_AW-1:0] pw_addr_reg;
    logic [BYTE_W-1:0] pw_data_reg;
    fwd_t              fwd_reg;
    fwd_t              fwd_sel;
    logic [OUT_CW-1:0] promised_reg;

    logic [BOX_AW-1:0] n_reg;
    logic [BYTE_W-1:0] acc_reg;
    logic [BYTE_W-1:0] held_reg;
    logic [KW-1:0]     kpos_reg;

    logic              accept;
    logic              key_in_range;
    logic [CFG_W-1:0]  key_len_eff;
    logic [CFG_W-1:0]  kpos_inc;
    logic [KW-1:0]     kpos_next;
    logic [BOX_AW-1:0] j_new;
    logic [BOX_AW-1:0] t_addr;
    logic [BYTE_W-1:0] acc_new;
    logic [BYTE_W-1:0] t_byte;

    // Items are taken while idle or in the last issue cycle of a crypt item,
    // as long as the output buffer can hold every promised result.
    assign in_stall = !(((state_reg == ST_IDLE) || (state_reg == ST_CR_RD_T))
                        && (promised_reg < OUT_CW'(OUT_DEPTH)));
    assign accept   = in_valid && !in_stall;

    // Key loads with an index below KEY_MAX go straight into the key memory at the accepting edge.
    assign key_in_range = ({1'b0, key_index} < CFG_W'(KEY_MAX));
    assign key_we       = accept && (func == FN_LOAD_KEY) && key_in_range;
    assign key_waddr    = key_index[KW-1:0];
    assign key_wdata    = in_byte;
    assign key_raddr    = kpos_reg;

    // Key length saturates at the key store depth.
    assign key_len_eff = (key_length > CFG_W'(KEY_MAX)) ? CFG_W'(KEY_MAX) : key_length;
    assign kpos_inc    = CFG_W'(kpos_reg) + CFG_W'(1);
    assign kpos_next   = (kpos_inc == key_len_eff) ? '0 : kpos_inc[KW-1:0];

    // Address arithmetic of the crypt and schedule steps.
    assign j_new   = j_reg + perm_rdata;
    assign t_addr  = a_reg + perm_rdata;
    assign acc_new = acc_reg + key_rdata + perm_rdata;

    // The output byte index may hit one of the two entries that are being
    // swapped; the swapped values are taken from registers then.
    always_comb
    begin
        if (t_addr == i_reg)
        begin
            fwd_sel = FWD_B;
        end
        else if (t_addr == j_reg)
        begin
            fwd_sel = FWD_A;
        end
        else
        begin
            fwd_sel = FWD_RAM;
        end
    end

    always_comb
    begin
        case (fwd_reg)
            FWD_A:   t_byte = a_reg;
            FWD_B:   t_byte = pw_data_reg;
            default: t_byte = perm_rdata;
        endcase
    end

    assign out_push.valid = post_reg;
    assign out_push.data  = cap_data_reg ^ t_byte;

    // Next state for a newly accepted item.
    always_comb
    begin
        if (func == FN_CRYPT)
        begin
            dispatch = ST_CR_RD_I;
        end
        else if ((func == FN_SCHEDULE) && (key_length != '0))
        begin
            dispatch = ST_KS_START;
        end
        else
        begin
            dispatch = ST_IDLE;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = dispatch;
                end
            end
            ST_CR_RD_I:   state_next = ST_CR_RD_J;
            ST_CR_RD_J:   state_next = ST_CR_RD_T;
            ST_CR_RD_T:   state_next = accept ? dispatch : ST_IDLE;
            ST_KS_START:  state_next = ST_KS_INIT;
            ST_KS_INIT:
            begin
                if (n_reg == LAST_N)
                begin
                    state_next = ST_KS_RD_N;
                end
            end
            ST_KS_RD_N:   state_next = ST_KS_RD_ACC;
            ST_KS_RD_ACC: state_next = ST_KS_WR_N;
            ST_KS_WR_N:   state_next = ST_KS_WR_ACC;
            ST_KS_WR_ACC: state_next = (n_reg == LAST_N) ? ST_IDLE : ST_KS_RD_N;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Permutation memory port. The deferred write of S[i] from a crypt item
    // lands in the cycle after its last issue cycle, which never writes.
    always_comb
    begin
        perm_req.we    = 1'b0;
        perm_req.waddr = '0;
        perm_req.wdata = '0;
        perm_req.raddr = i_reg;
        case (state_reg)
            ST_CR_RD_J:
            begin
                perm_req.raddr = j_new;
            end
            ST_CR_RD_T:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = j_reg;
                perm_req.wdata = a_reg;
                perm_req.raddr = t_addr;
            end
            ST_KS_INIT:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = n_reg;
                perm_req.wdata = n_reg;
            end
            ST_KS_RD_N:
            begin
                perm_req.raddr = n_reg;
            end
            ST_KS_RD_ACC:
            begin
                perm_req.raddr = acc_new;
            end
            ST_KS_WR_N:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = n_reg;
                perm_req.wdata = perm_rdata;
            end
            ST_KS_WR_ACC:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = acc_reg;
                perm_req.wdata = held_reg;
            end
            default:
            begin
                perm_req.raddr = i_reg;
            end
        endcase
        if (post_reg)
        begin
            perm_req.we    = 1'b1;
            perm_req.waddr = pw_addr_reg;
            perm_req.wdata = pw_data_reg;
        end
    end

    // Control state, indices and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            i_reg        <= BOX_AW'(1);
            j_reg        <= '0;
            post_reg     <= 1'b0;
            promised_reg <= '0;
            n_reg        <= '0;
            acc_reg      <= '0;
            kpos_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            post_reg     <= (state_reg == ST_CR_RD_T);
            promised_reg <= promised_reg
                            + OUT_CW'(accept && (func == FN_CRYPT))
                            - OUT_CW'(out_pop);
            case (state_reg)
                ST_CR_RD_J:
                begin
                    j_reg <= j_new;
                end
                ST_CR_RD_T:
                begin
                    i_reg <= i_reg + BOX_AW'(1);
                end
                ST_KS_START:
                begin
                    n_reg <= '0;
                end
                ST_KS_INIT:
                begin
                    n_reg <= n_reg + BOX_AW'(1);
                    if (n_reg == LAST_N)
                    begin
                        acc_reg  <= '0;
                        kpos_reg <= '0;
                    end
                end
                ST_KS_RD_ACC:
                begin
                    acc_reg  <= acc_new;
                    kpos_reg <= kpos_next;
                end
                ST_KS_WR_ACC:
                begin
                    n_reg <= n_reg + BOX_AW'(1);
                    if (n_reg == LAST_N)
                    begin
                        i_reg <= BOX_AW'(1);
                        j_reg <= '0;
                    end
                end
                default:
                begin
                    n_reg <= n_reg;
                end
            endcase
        end
    end

    // Payload registers of the crypt and schedule steps.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= in_byte;
        end
        if (state_reg == ST_CR_RD_J)
        begin
            a_reg <= perm_rdata;
        end
        if (state_reg == ST_CR_RD_T)
        begin
            pw_addr_reg  <= i_reg;
            pw_data_reg  <= perm_rdata;
            fwd_reg      <= fwd_sel;
            cap_data_reg <= data_reg;
        end
        if (state_reg == ST_KS_RD_ACC)
        begin
            held_reg <= perm_rdata;
        end
    end

endmodule

/* hw/rtl/arc4_checker.sv */
`timescale 1ns / 1ps

module arc4_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [1:0]                  func,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [arc4_pkg::BYTE_W-1:0] out_byte,
    input logic                        key_length_we,
    input logic [arc4_pkg::CFG_W-1:0]  key_length
);
    import arc4_pkg::*;

    logic              in_acc;
    logic              out_acc;
    logic [1:0]        outstanding_reg;
    logic [CFG_W-1:0]  kl_reg;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Crypt items accepted whose results were not yet taken, and a copy of
    // the key length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            kl_reg          <= KEY_LEN_RESET;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 2'(in_acc && (func == FN_CRYPT))
                               - 2'(out_acc);
            if (key_length_we)
            begin
                kl_reg <= key_length;
            end
        end
    end

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte))
        else $error("result changed while stalled");

    // Every result shown belongs to an accepted crypt item.
    a_out_owned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outstanding_reg != 2'd0)
        else $error("result without a crypt item");

    // No more results are promised than the output buffer holds.
    a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 2'(OUT_DEPTH))
        else $error("too many crypt items in flight");

    // A crypt item keeps the input stalled while it reads S[i] and S[j].
    a_crypt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (func == FN_CRYPT) |=> in_stall ##1 in_stall)
        else $error("item taken during a crypt item");

    // A key schedule with a nonzero key length keeps the input stalled in its start state and the first sweep state.
    a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (func == FN_SCHEDULE) && (kl_reg != '0) |=> in_stall ##1 in_stall)
        else $error("item taken during the key schedule");

endmodule

bind arc4_stream_cipher arc4_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .key_length_we (key_length_we),
    .key_length    (key_length)
);
